@@ design/ray_quad_intersect_macros.svh @@
// assertion macros shared by the ray / quad intersection design
`ifndef RAY_QUAD_INTERSECT_MACROS_SVH
`define RAY_QUAD_INTERSECT_MACROS_SVH

// same-cycle implication, masked while reset is held
`define RQI_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, reset handled by the caller
`define RQI_ASSERT_NXT(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

@@ design/rqi_pkg.sv @@
// shared constants for the ray / quad intersection design
package rqi_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 63;
    localparam int COMP_W     = 21;
    localparam int VEC_W      = 63;
    localparam int OFFSET_W   = 32;
    localparam int INV_W      = 31;

    localparam logic [CFG_IDX_W-1:0] REG_CORNER = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EDGE_U = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_EDGE_V = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_NORMAL = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_INV_U  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_INV_V  = 3'd7;

endpackage

@@ design/rqi_ray_if.sv @@
// ray input channel
interface rqi_ray_if #(
    parameter int W = 32
);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] origin_x;
    logic signed [W-1:0] origin_y;
    logic signed [W-1:0] origin_z;
    logic signed [W-1:0] dir_x;
    logic signed [W-1:0] dir_y;
    logic signed [W-1:0] dir_z;
    logic signed [W-1:0] t_min;
    logic signed [W-1:0] t_max;

    modport source (
        output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, t_min, t_max,
        input  ready
    );
    modport sink (
        input  valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, t_min, t_max,
        output ready
    );
endinterface

@@ design/rqi_hit_if.sv @@
// intersection result channel
interface rqi_hit_if #(
    parameter int W = 32
);
    logic                valid;
    logic                ready;
    logic                hit;
    logic signed [W-1:0] distance;
    logic signed [W-1:0] point_x;
    logic signed [W-1:0] point_y;
    logic signed [W-1:0] point_z;
    logic signed [W-1:0] surf_u;
    logic signed [W-1:0] surf_v;
    logic                front_face;

    modport source (
        output valid, hit, distance, point_x, point_y, point_z, surf_u, surf_v, front_face,
        input  ready
    );
    modport sink (
        input  valid, hit, distance, point_x, point_y, point_z, surf_u, surf_v, front_face,
        output ready
    );
endinterface

@@ design/rqi_cfg_if.sv @@
// configuration write channel
interface rqi_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [rqi_pkg::CFG_IDX_W-1:0]    reg_idx;
    logic [rqi_pkg::CFG_DATA_W-1:0]   wdata;

    modport source (output valid, reg_idx, wdata, input ready);
    modport sink (input valid, reg_idx, wdata, output ready);
endinterface

@@ design/ray_quad_intersect.sv @@
// ray / parallelogram intersection pipeline, one ray per clock unless the output stalls
// the restoring divider, one quotient bit per stage, sets most of the pipeline depth
// throughput: one ray per cycle while the output is not stalled; a stalled output freezes the whole pipeline
// reset: synchronous active-low, clears all stage valid bits and the configuration registers to zero
module ray_quad_intersect #(
    parameter int SCALAR_WIDTH = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rqi_ray_if.sink   i_ray,
    rqi_cfg_if.sink   i_cfg,
    rqi_hit_if.source o_hit
);

    `include "ray_quad_intersect_macros.svh"

    localparam int SW   = SCALAR_WIDTH;
    localparam int DW   = (SW < 32) ? SW : 32;
    localparam int CPW  = rqi_pkg::COMP_W;
    localparam int PW   = DW + CPW;
    localparam int SUMW = PW + 2;
    localparam int DEW  = SUMW - 10;
    localparam int NUMW = ((DEW > rqi_pkg::OFFSET_W) ? DEW : rqi_pkg::OFFSET_W) + 1;
    localparam int NMW  = NUMW + 16;
    localparam int QB   = DW + 1;
    localparam int WR   = DEW + QB;
    localparam int TW   = DW + 2;
    localparam int PDW  = 2 * DW;
    localparam int HW   = ((DW > 27) ? DW : 27) + 1;
    localparam int HPW  = HW + CPW;
    localparam int CW   = HPW + 1;
    localparam int CSW  = CW - 12;
    localparam int DUW  = HPW + 2;
    localparam int XW   = DUW - 10;
    localparam int WPW  = CSW + CPW;
    localparam int SUMA = WPW + 2;
    localparam int HIW  = rqi_pkg::INV_W - 16;
    localparam int LOW  = 16;
    localparam int SATW = ((2 * DW + 1) > (XW + 18)) ? (2 * DW + 1) : (XW + 18);

    localparam logic signed [SW-1:0]   IN_HI   = SW'((64'sd1 <<< (DW - 1)) - 64'sd1);
    localparam logic signed [SW-1:0]   IN_LO   = -IN_HI - SW'(1);
    localparam logic signed [SATW-1:0] SAT_HI  = SATW'((64'sd1 <<< (DW - 1)) - 64'sd1);
    localparam logic signed [SATW-1:0] SAT_LO  = -SAT_HI - SATW'(1);
    localparam logic signed [SUMW-1:0] PAR_LIM = SUMW'(1024);
    localparam logic signed [SUMA-1:0] ONE_Q34 = SUMA'(64'sd1 <<< 34);

    typedef struct packed {
        logic [2:0][DW-1:0] o;
        logic [2:0][DW-1:0] d;
        logic [DW-1:0]      tmin;
        logic [DW-1:0]      tmax;
    } t_ray;

    typedef struct packed {
        logic [WR-1:0]  rem;
        logic [DEW-1:0] dm;
        logic [QB-1:0]  quo;
        logic           neg;
        logic           front;
        logic           miss;
        t_ray           ray;
    } t_div;

    function automatic logic signed [DW-1:0] sat_in(input logic signed [SW-1:0] x);
        logic signed [SW-1:0] y;
        y = (x > IN_HI) ? IN_HI : ((x < IN_LO) ? IN_LO : x);
        return DW'(y);
    endfunction

    function automatic logic signed [DW-1:0] sat_dw(input logic signed [SATW-1:0] x);
        logic signed [SATW-1:0] y;
        y = (x > SAT_HI) ? SAT_HI : ((x < SAT_LO) ? SAT_LO : x);
        return DW'(y);
    endfunction

    // configuration registers
    logic [rqi_pkg::VEC_W-1:0]    r_corner, r_edge_u, r_edge_v, r_normal, r_scale;
    logic [rqi_pkg::OFFSET_W-1:0] r_offset;
    logic [rqi_pkg::INV_W-1:0]    r_inv_u, r_inv_v;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_corner <= '0;
            r_edge_u <= '0;
            r_edge_v <= '0;
            r_normal <= '0;
            r_scale  <= '0;
            r_offset <= '0;
            r_inv_u  <= '0;
            r_inv_v  <= '0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.reg_idx)
                rqi_pkg::REG_CORNER: r_corner <= i_cfg.wdata;
                rqi_pkg::REG_EDGE_U: r_edge_u <= i_cfg.wdata;
                rqi_pkg::REG_EDGE_V: r_edge_v <= i_cfg.wdata;
                rqi_pkg::REG_NORMAL: r_normal <= i_cfg.wdata;
                rqi_pkg::REG_SCALE:  r_scale  <= i_cfg.wdata;
                rqi_pkg::REG_OFFSET: r_offset <= i_cfg.wdata[rqi_pkg::OFFSET_W-1:0];
                rqi_pkg::REG_INV_U:  r_inv_u  <= i_cfg.wdata[rqi_pkg::INV_W-1:0];
                rqi_pkg::REG_INV_V:  r_inv_v  <= i_cfg.wdata[rqi_pkg::INV_W-1:0];
            endcase
        end
    end

    logic signed [CPW-1:0] c_q [3];
    logic signed [CPW-1:0] c_eu [3];
    logic signed [CPW-1:0] c_ev [3];
    logic signed [CPW-1:0] c_n [3];
    logic signed [CPW-1:0] c_w [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            c_q[i]  = r_corner[i*CPW +: CPW];
            c_eu[i] = r_edge_u[i*CPW +: CPW];
            c_ev[i] = r_edge_v[i*CPW +: CPW];
            c_n[i]  = r_normal[i*CPW +: CPW];
            c_w[i]  = r_scale[i*CPW +: CPW];
        end
    end

    // pipeline advance: the whole pipe moves unless the result register is held
    logic r_out_v;
    logic en;
    assign en          = !r_out_v || o_hit.ready;
    assign i_ray.ready = en;

    // stage 1: clamp inputs to the datapath range
    logic r_s1_v;
    t_ray r_s1_ray;

    // stage 2: dot product terms
    logic                   r_s2_v;
    t_ray                   r_s2_ray;
    logic signed [PW-1:0]   r_s2_pd [3];
    logic signed [PW-1:0]   r_s2_po [3];

    // stage 3: dot product sums
    logic                   r_s3_v;
    t_ray                   r_s3_ray;
    logic signed [SUMW-1:0] r_s3_denom;
    logic signed [SUMW-1:0] r_s3_doto;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_ray.o[0] <= sat_in(i_ray.origin_x);
            r_s1_ray.o[1] <= sat_in(i_ray.origin_y);
            r_s1_ray.o[2] <= sat_in(i_ray.origin_z);
            r_s1_ray.d[0] <= sat_in(i_ray.dir_x);
            r_s1_ray.d[1] <= sat_in(i_ray.dir_y);
            r_s1_ray.d[2] <= sat_in(i_ray.dir_z);
            r_s1_ray.tmin <= sat_in(i_ray.t_min);
            r_s1_ray.tmax <= sat_in(i_ray.t_max);

            r_s2_ray <= r_s1_ray;
            for (int i = 0; i < 3; i++) begin
                r_s2_pd[i] <= PW'(c_n[i] * $signed(r_s1_ray.d[i]));
                r_s2_po[i] <= PW'(c_n[i] * $signed(r_s1_ray.o[i]));
            end

            r_s3_ray   <= r_s2_ray;
            r_s3_denom <= SUMW'(r_s2_pd[0]) + SUMW'(r_s2_pd[1]) + SUMW'(r_s2_pd[2]);
            r_s3_doto  <= SUMW'(r_s2_po[0]) + SUMW'(r_s2_po[1]) + SUMW'(r_s2_po[2]);
        end
    end

    // divider setup: magnitudes, sign, parallel and overflow checks
    t_div             r_div [QB+1];
    logic [QB:0]      r_div_v;
    t_div             n_div0;
    logic signed [NUMW-1:0] w_num;
    logic signed [DEW-1:0]  w_den16;
    logic [NUMW-1:0]        w_num_mag;
    logic [WR-1:0]          w_nmag;

    always_comb begin
        w_num     = NUMW'($signed(r_offset)) - NUMW'(r_s3_doto >>> 10);
        w_den16   = DEW'(r_s3_denom >>> 10);
        w_num_mag = w_num[NUMW-1] ? NUMW'(-w_num) : NUMW'(w_num);
        w_nmag    = WR'({w_num_mag, 16'h0000});
        n_div0.rem   = w_nmag;
        n_div0.dm    = w_den16[DEW-1] ? DEW'(-w_den16) : DEW'(w_den16);
        n_div0.quo   = '0;
        n_div0.neg   = w_num[NUMW-1] ^ w_den16[DEW-1];
        n_div0.front = r_s3_denom[SUMW-1];
        // parallel ray, or a quotient too large for any window
        n_div0.miss  = (r_s3_denom >= -PAR_LIM && r_s3_denom <= PAR_LIM)
                     || ((w_nmag >> QB) >= WR'(n_div0.dm));
        n_div0.ray   = r_s3_ray;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_div[0] <= n_div0;
        end
    end

    // restoring division, one quotient bit per stage
    for (genvar j = 0; j < QB; j++) begin : g_div
        localparam int K = QB - 1 - j;
        t_div          n_div;
        logic [WR-1:0] trial;

        always_comb begin
            n_div = r_div[j];
            trial = WR'(r_div[j].dm) << K;
            if (r_div[j].rem >= trial) begin
                n_div.rem    = r_div[j].rem - trial;
                n_div.quo[K] = 1'b1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_div[j+1] <= n_div;
            end
        end
    end

    // stage 5: signed distance and window test
    logic                 r_s5_v;
    t_ray                 r_s5_ray;
    logic signed [DW-1:0] r_s5_t;
    logic                 r_s5_miss;
    logic                 r_s5_front;
    logic signed [TW-1:0] w_t;

    always_comb begin
        w_t = r_div[QB].neg ? -$signed(TW'(r_div[QB].quo)) : $signed(TW'(r_div[QB].quo));
    end

    // stage 6: direction times distance
    logic                  r_s6_v;
    t_ray                  r_s6_ray;
    logic signed [DW-1:0]  r_s6_t;
    logic                  r_s6_miss;
    logic                  r_s6_front;
    logic signed [PDW-1:0] r_s6_pdt [3];

    // stage 7: hit point and offset from the corner
    logic                 r_s7_v;
    logic signed [DW-1:0] r_s7_t;
    logic                 r_s7_miss;
    logic                 r_s7_front;
    logic signed [DW-1:0] r_s7_p [3];
    logic signed [HW-1:0] r_s7_h [3];

    // stage 8: offset times edge components
    logic                  r_s8_v;
    logic signed [DW-1:0]  r_s8_t;
    logic                  r_s8_miss;
    logic                  r_s8_front;
    logic signed [DW-1:0]  r_s8_p [3];
    logic signed [HPW-1:0] r_s8_hu [3][3];
    logic signed [HPW-1:0] r_s8_hv [3][3];

    // stage 9: cross products and edge dots
    logic                  r_s9_v;
    logic signed [DW-1:0]  r_s9_t;
    logic                  r_s9_miss;
    logic                  r_s9_front;
    logic signed [DW-1:0]  r_s9_p [3];
    logic signed [CSW-1:0] r_s9_ca [3];
    logic signed [CSW-1:0] r_s9_cb [3];
    logic signed [XW-1:0]  r_s9_du;
    logic signed [XW-1:0]  r_s9_dv;

    // stage 10: planar weights and edge scaling
    logic                     r_s10_v;
    logic signed [DW-1:0]     r_s10_t;
    logic                     r_s10_miss;
    logic                     r_s10_front;
    logic signed [DW-1:0]     r_s10_p [3];
    logic signed [WPW-1:0]    r_s10_wa [3];
    logic signed [WPW-1:0]    r_s10_wb [3];
    logic signed [XW+HIW:0]   r_s10_uhi;
    logic signed [XW+LOW:0]   r_s10_ulo;
    logic signed [XW+HIW:0]   r_s10_vhi;
    logic signed [XW+LOW:0]   r_s10_vlo;

    logic signed [HPW-1:0] w_ca [3];
    logic signed [HPW-1:0] w_cb [3];

    always_comb begin
        w_ca[0] = r_s8_hv[1][2];
        w_ca[1] = r_s8_hv[2][0];
        w_ca[2] = r_s8_hv[0][1];
        w_cb[0] = r_s8_hu[2][1];
        w_cb[1] = r_s8_hu[0][2];
        w_cb[2] = r_s8_hu[1][0];
    end

    logic signed [HPW-1:0] w_ca_sub [3];
    logic signed [HPW-1:0] w_cb_sub [3];

    always_comb begin
        w_ca_sub[0] = r_s8_hv[2][1];
        w_ca_sub[1] = r_s8_hv[0][2];
        w_ca_sub[2] = r_s8_hv[1][0];
        w_cb_sub[0] = r_s8_hu[1][2];
        w_cb_sub[1] = r_s8_hu[2][0];
        w_cb_sub[2] = r_s8_hu[0][1];
    end

    logic signed [HIW:0] w_inv_u_hi, w_inv_v_hi;
    logic signed [LOW:0] w_inv_u_lo, w_inv_v_lo;

    assign w_inv_u_hi = $signed({1'b0, r_inv_u[rqi_pkg::INV_W-1:LOW]});
    assign w_inv_v_hi = $signed({1'b0, r_inv_v[rqi_pkg::INV_W-1:LOW]});
    assign w_inv_u_lo = $signed({1'b0, r_inv_u[LOW-1:0]});
    assign w_inv_v_lo = $signed({1'b0, r_inv_v[LOW-1:0]});

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s5_ray   <= r_div[QB].ray;
            r_s5_t     <= DW'(w_t);
            r_s5_front <= r_div[QB].front;
            r_s5_miss  <= r_div[QB].miss
                       || (w_t < TW'($signed(r_div[QB].ray.tmin)))
                       || (w_t > TW'($signed(r_div[QB].ray.tmax)));

            r_s6_ray   <= r_s5_ray;
            r_s6_t     <= r_s5_t;
            r_s6_miss  <= r_s5_miss;
            r_s6_front <= r_s5_front;
            for (int i = 0; i < 3; i++) begin
                r_s6_pdt[i] <= PDW'($signed(r_s5_ray.d[i]) * r_s5_t);
            end

            r_s7_t     <= r_s6_t;
            r_s7_miss  <= r_s6_miss;
            r_s7_front <= r_s6_front;
            for (int i = 0; i < 3; i++) begin
                r_s7_p[i] <= sat_dw(SATW'($signed(r_s6_ray.o[i])) + SATW'(r_s6_pdt[i] >>> 16));
                r_s7_h[i] <= HW'(sat_dw(SATW'($signed(r_s6_ray.o[i]))
                                 + SATW'(r_s6_pdt[i] >>> 16)))
                           - (HW'(c_q[i]) <<< 6);
            end

            r_s8_t     <= r_s7_t;
            r_s8_miss  <= r_s7_miss;
            r_s8_front <= r_s7_front;
            for (int i = 0; i < 3; i++) begin
                r_s8_p[i] <= r_s7_p[i];
                for (int k = 0; k < 3; k++) begin
                    r_s8_hu[i][k] <= HPW'(r_s7_h[i] * c_eu[k]);
                    r_s8_hv[i][k] <= HPW'(r_s7_h[i] * c_ev[k]);
                end
            end

            r_s9_t     <= r_s8_t;
            r_s9_miss  <= r_s8_miss;
            r_s9_front <= r_s8_front;
            for (int i = 0; i < 3; i++) begin
                r_s9_p[i]  <= r_s8_p[i];
                r_s9_ca[i] <= CSW'((CW'(w_ca[i]) - CW'(w_ca_sub[i])) >>> 12);
                r_s9_cb[i] <= CSW'((CW'(w_cb[i]) - CW'(w_cb_sub[i])) >>> 12);
            end
            r_s9_du <= XW'((DUW'(r_s8_hu[0][0]) + DUW'(r_s8_hu[1][1])
                           + DUW'(r_s8_hu[2][2])) >>> 10);
            r_s9_dv <= XW'((DUW'(r_s8_hv[0][0]) + DUW'(r_s8_hv[1][1])
                           + DUW'(r_s8_hv[2][2])) >>> 10);

            r_s10_t     <= r_s9_t;
            r_s10_miss  <= r_s9_miss;
            r_s10_front <= r_s9_front;
            for (int i = 0; i < 3; i++) begin
                r_s10_p[i]  <= r_s9_p[i];
                r_s10_wa[i] <= WPW'(c_w[i] * r_s9_ca[i]);
                r_s10_wb[i] <= WPW'(c_w[i] * r_s9_cb[i]);
            end
            r_s10_uhi <= (XW+HIW+1)'(r_s9_du * w_inv_u_hi);
            r_s10_ulo <= (XW+LOW+1)'(r_s9_du * w_inv_u_lo);
            r_s10_vhi <= (XW+HIW+1)'(r_s9_dv * w_inv_v_hi);
            r_s10_vlo <= (XW+LOW+1)'(r_s9_dv * w_inv_v_lo);
        end
    end

    // output register: interior test, edge projections, zeroing on a miss
    logic                  r_out_hit;
    logic signed [DW-1:0]  r_out_dist;
    logic signed [DW-1:0]  r_out_p [3];
    logic signed [DW-1:0]  r_out_su;
    logic signed [DW-1:0]  r_out_sv;
    logic                  r_out_front;
    logic signed [SUMA-1:0] w_sa, w_sb;
    logic                   w_hit;

    always_comb begin
        w_sa  = SUMA'(r_s10_wa[0]) + SUMA'(r_s10_wa[1]) + SUMA'(r_s10_wa[2]);
        w_sb  = SUMA'(r_s10_wb[0]) + SUMA'(r_s10_wb[1]) + SUMA'(r_s10_wb[2]);
        w_hit = !r_s10_miss && (w_sa >= 0) && (w_sa <= ONE_Q34)
                && (w_sb >= 0) && (w_sb <= ONE_Q34);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_hit   <= w_hit;
            r_out_dist  <= w_hit ? r_s10_t : '0;
            r_out_front <= w_hit && r_s10_front;
            for (int i = 0; i < 3; i++) begin
                r_out_p[i] <= w_hit ? r_s10_p[i] : '0;
            end
            r_out_su <= w_hit ? sat_dw(SATW'(r_s10_uhi) + SATW'(r_s10_ulo >>> 16)) : '0;
            r_out_sv <= w_hit ? sat_dw(SATW'(r_s10_vhi) + SATW'(r_s10_vlo >>> 16)) : '0;
        end
    end

    // stage valid bits
    logic r_s5_v_unused_guard;
    assign r_s5_v_unused_guard = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v  <= 1'b0;
            r_s2_v  <= 1'b0;
            r_s3_v  <= 1'b0;
            r_div_v <= '0;
            r_s5_v  <= 1'b0;
            r_s6_v  <= 1'b0;
            r_s7_v  <= 1'b0;
            r_s8_v  <= 1'b0;
            r_s9_v  <= 1'b0;
            r_s10_v <= 1'b0;
            r_out_v <= 1'b0;
        end else if (en) begin
            r_s1_v  <= i_ray.valid;
            r_s2_v  <= r_s1_v;
            r_s3_v  <= r_s2_v;
            r_div_v <= {r_div_v[QB-1:0], r_s3_v};
            r_s5_v  <= r_div_v[QB] | r_s5_v_unused_guard;
            r_s6_v  <= r_s5_v;
            r_s7_v  <= r_s6_v;
            r_s8_v  <= r_s7_v;
            r_s9_v  <= r_s8_v;
            r_s10_v <= r_s9_v;
            r_out_v <= r_s10_v;
        end
    end

    assign o_hit.valid      = r_out_v;
    assign o_hit.hit        = r_out_hit;
    assign o_hit.distance   = SW'(r_out_dist);
    assign o_hit.point_x    = SW'(r_out_p[0]);
    assign o_hit.point_y    = SW'(r_out_p[1]);
    assign o_hit.point_z    = SW'(r_out_p[2]);
    assign o_hit.surf_u     = SW'(r_out_su);
    assign o_hit.surf_v     = SW'(r_out_sv);
    assign o_hit.front_face = r_out_front;

    logic [QB+10:0] w_vld;
    assign w_vld = {r_s1_v, r_s2_v, r_s3_v, r_div_v, r_s5_v, r_s6_v, r_s7_v,
                    r_s8_v, r_s9_v, r_s10_v, r_out_v};

    `RQI_ASSERT_IMP(a_miss_zero, i_clk, i_rst_n, r_out_v && !r_out_hit,
        r_out_dist == '0 && !r_out_front && r_out_su == '0 && r_out_sv == '0
        && r_out_p[0] == '0, "miss result carries non-zero fields")
    `RQI_ASSERT_NXT(a_stall_hold, i_clk, i_rst_n && !en, $stable(w_vld),
        "pipeline moved while stalled")
    `RQI_ASSERT_NXT(a_reset_clear, i_clk, !i_rst_n, w_vld == '0,
        "stage valid bits not cleared by reset")

endmodule
